FILE: rtl/imh_pkg.sv
// shared types and constants for the indexed min-heap
`timescale 1ns / 1ps
package imh_pkg;

    // field widths on the ports
    localparam int KIND_W   = 2;
    localparam int ID_W     = 8;
    localparam int KEY_W    = 32;
    localparam int STATUS_W = 2;
    localparam int CNT_W    = 9;
    localparam int APB_AW   = 3;
    localparam int APB_DW   = 32;

    // default sizes
    localparam int DEF_CAPACITY = 256;
    localparam int DEF_NUM_IDS  = 256;
    localparam int DEF_KEY_BITS = 32;

    // reset value of the capacity limit register
    localparam logic [CNT_W-1:0] CAP_LIMIT_RESET = 9'd256;

    // register index taken from the word address bit
    localparam logic REG_CAPACITY_LIMIT = 1'b0;

    // request kind codes
    localparam logic [KIND_W-1:0] KIND_ADD    = 2'd0;
    localparam logic [KIND_W-1:0] KIND_REMOVE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_UPDATE = 2'd2;
    localparam logic [KIND_W-1:0] KIND_QUERY  = 2'd3;

    // result status codes
    typedef enum logic [STATUS_W-1:0] {
        STAT_OK      = 2'd0,
        STAT_FULL    = 2'd1,
        STAT_ABSENT  = 2'd2,
        STAT_PRESENT = 2'd3
    } status_t;

    // classified operation handed to the back end
    typedef enum logic [2:0] {
        OP_ADD,
        OP_REMOVE,
        OP_UPDATE,
        OP_QUERY,
        OP_BAD_ID
    } op_t;

    // control part of a queued request
    typedef struct packed {
        logic valid;
        op_t  op;
    } req_ctrl_t;

    // heap engine states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_POS_WAIT,
        ST_LAST_WAIT,
        ST_UP,
        ST_UP_WAIT,
        ST_DOWN,
        ST_DL_WAIT,
        ST_DR_WAIT,
        ST_DECIDE,
        ST_WRITE,
        ST_DONE
    } state_t;

endpackage

FILE: rtl/indexed_min_heap_top.sv
// indexed min-heap: apb register, request front end and heap engine
// throughput: one request at a time in the heap engine, set by its single-read heap memory;
// a two-entry queue takes requests while the engine works; the result register holds one
// reset: all ids absent, count zero, capacity limit 256; heap memory needs no clearing
`timescale 1ns / 1ps
module indexed_min_heap_top #(
    parameter int CAPACITY = imh_pkg::DEF_CAPACITY,
    parameter int NUM_IDS  = imh_pkg::DEF_NUM_IDS,
    parameter int KEY_BITS = imh_pkg::DEF_KEY_BITS
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [imh_pkg::KIND_W-1:0]    kind,
    input  logic [imh_pkg::ID_W-1:0]      entry_id,
    input  logic [imh_pkg::KEY_W-1:0]     key,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [imh_pkg::STATUS_W-1:0]  status,
    output logic                          min_valid,
    output logic [imh_pkg::ID_W-1:0]      min_id,
    output logic [imh_pkg::KEY_W-1:0]     min_key,
    output logic [imh_pkg::CNT_W-1:0]     count,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [imh_pkg::APB_AW-1:0]    paddr,
    input  logic [imh_pkg::APB_DW-1:0]    pwdata,
    output logic [imh_pkg::APB_DW-1:0]    prdata,
    output logic                          pready
);

    localparam int ID_IW = $clog2(NUM_IDS);

    logic [imh_pkg::CNT_W-1:0] cap_limit_reg;
    imh_pkg::req_ctrl_t        head_ctrl;
    logic [ID_IW-1:0]          head_id;
    logic [KEY_BITS-1:0]       head_key;
    logic                      head_pop;

    // capacity limit register
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_limit_reg <= imh_pkg::CAP_LIMIT_RESET;
        end
        else if (psel && penable && pwrite && paddr[2] == imh_pkg::REG_CAPACITY_LIMIT)
        begin
            cap_limit_reg <= pwdata[imh_pkg::CNT_W-1:0];
        end
    end

    assign prdata = (paddr[2] == imh_pkg::REG_CAPACITY_LIMIT)
                  ? imh_pkg::APB_DW'(cap_limit_reg) : '0;

    imh_front #(
        .NUM_IDS  (NUM_IDS),
        .KEY_BITS (KEY_BITS),
        .ID_IW    (ID_IW)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .kind      (kind),
        .entry_id  (entry_id),
        .key       (key),
        .head_ctrl (head_ctrl),
        .head_id   (head_id),
        .head_key  (head_key),
        .head_pop  (head_pop)
    );

    imh_engine #(
        .CAPACITY (CAPACITY),
        .NUM_IDS  (NUM_IDS),
        .KEY_BITS (KEY_BITS),
        .ID_IW    (ID_IW)
    ) u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .head_ctrl (head_ctrl),
        .head_id   (head_id),
        .head_key  (head_key),
        .head_pop  (head_pop),
        .cap_limit (cap_limit_reg),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .min_valid (min_valid),
        .min_id    (min_id),
        .min_key   (min_key),
        .count     (count)
    );

endmodule

FILE: rtl/imh_ram.sv
// generic single write port ram with registered read
`timescale 1ns / 1ps
module imh_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: rtl/imh_front.sv
// front end: accepts requests, classifies them and queues them
`timescale 1ns / 1ps
module imh_front #(
    parameter int NUM_IDS  = imh_pkg::DEF_NUM_IDS,
    parameter int KEY_BITS = imh_pkg::DEF_KEY_BITS,
    parameter int ID_IW    = $clog2(NUM_IDS)
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [imh_pkg::KIND_W-1:0]  kind,
    input  logic [imh_pkg::ID_W-1:0]    entry_id,
    input  logic [imh_pkg::KEY_W-1:0]   key,
    output imh_pkg::req_ctrl_t          head_ctrl,
    output logic [ID_IW-1:0]            head_id,
    output logic [KEY_BITS-1:0]         head_key,
    input  logic                        head_pop
);

    localparam int IDX_W = ((ID_IW > imh_pkg::ID_W) ? ID_IW : imh_pkg::ID_W) + 1;
    localparam int KW_MAX = (KEY_BITS > imh_pkg::KEY_W) ? KEY_BITS : imh_pkg::KEY_W;

    imh_pkg::op_t            op_q   [2];
    logic [ID_IW-1:0]        id_q   [2];
    logic [KEY_BITS-1:0]     key_q  [2];
    logic                    wr_ptr_reg;
    logic                    rd_ptr_reg;
    logic [1:0]              fill_reg;
    logic [1:0]              fill_next;

    imh_pkg::op_t            cls_op;
    logic [IDX_W-1:0]        id_wide;
    logic [KW_MAX-1:0]       key_wide;
    logic                    push;
    logic                    pop;

    // classify the incoming request
    assign id_wide  = IDX_W'(entry_id);
    assign key_wide = KW_MAX'(key);

    always_comb
    begin
        unique case (kind)
            imh_pkg::KIND_ADD:    cls_op = imh_pkg::OP_ADD;
            imh_pkg::KIND_REMOVE: cls_op = imh_pkg::OP_REMOVE;
            imh_pkg::KIND_UPDATE: cls_op = imh_pkg::OP_UPDATE;
            default:              cls_op = imh_pkg::OP_QUERY;
        endcase
        if (kind != imh_pkg::KIND_QUERY && id_wide >= IDX_W'(NUM_IDS))
        begin
            cls_op = imh_pkg::OP_BAD_ID;
        end
    end

    // two-entry request queue
    assign in_ready = (fill_reg != 2'd2);
    assign push     = in_valid && in_ready;
    assign pop      = head_pop && (fill_reg != 2'd0);

    always_comb
    begin
        fill_next = fill_reg;
        if (push && !pop)
        begin
            fill_next = fill_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            fill_next = fill_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            fill_reg <= fill_next;
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
        end
    end

    // queue payload storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            op_q[wr_ptr_reg]  <= cls_op;
            id_q[wr_ptr_reg]  <= id_wide[ID_IW-1:0];
            key_q[wr_ptr_reg] <= key_wide[KEY_BITS-1:0];
        end
    end

    assign head_ctrl.valid = (fill_reg != 2'd0);
    assign head_ctrl.op    = op_q[rd_ptr_reg];
    assign head_id         = id_q[rd_ptr_reg];
    assign head_key        = key_q[rd_ptr_reg];

endmodule

FILE: rtl/imh_engine.sv
// back end: heap sequencer with position table and result register
`timescale 1ns / 1ps
module imh_engine #(
    parameter int CAPACITY = imh_pkg::DEF_CAPACITY,
    parameter int NUM_IDS  = imh_pkg::DEF_NUM_IDS,
    parameter int KEY_BITS = imh_pkg::DEF_KEY_BITS,
    parameter int ID_IW    = $clog2(NUM_IDS)
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  imh_pkg::req_ctrl_t            head_ctrl,
    input  logic [ID_IW-1:0]              head_id,
    input  logic [KEY_BITS-1:0]           head_key,
    output logic                          head_pop,
    input  logic [imh_pkg::CNT_W-1:0]     cap_limit,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [imh_pkg::STATUS_W-1:0]  status,
    output logic                          min_valid,
    output logic [imh_pkg::ID_W-1:0]      min_id,
    output logic [imh_pkg::KEY_W-1:0]     min_key,
    output logic [imh_pkg::CNT_W-1:0]     count
);

    localparam int SLOT_W = $clog2(CAPACITY);
    localparam int HC_W   = $clog2(CAPACITY + 1);
    localparam int XW     = SLOT_W + 2;
    localparam int LW     = (HC_W > imh_pkg::CNT_W) ? HC_W : imh_pkg::CNT_W;
    localparam int HW     = KEY_BITS + ID_IW;
    localparam int IDM    = (ID_IW > imh_pkg::ID_W) ? ID_IW : imh_pkg::ID_W;
    localparam int KW_MAX = (KEY_BITS > imh_pkg::KEY_W) ? KEY_BITS : imh_pkg::KEY_W;
    localparam int CW_MAX = (HC_W > imh_pkg::CNT_W) ? HC_W : imh_pkg::CNT_W;

    imh_pkg::state_t          state_reg, state_next;
    imh_pkg::op_t             op_reg, op_next;
    imh_pkg::status_t         stat_reg, stat_next;
    logic [ID_IW-1:0]         id_reg, id_next;
    logic [KEY_BITS-1:0]      key_reg, key_next;
    logic [SLOT_W-1:0]        i_reg, i_next;
    logic [KEY_BITS-1:0]      cur_key_reg, cur_key_next;
    logic [ID_IW-1:0]         cur_id_reg, cur_id_next;
    logic [SLOT_W-1:0]        best_reg, best_next;
    logic [KEY_BITS-1:0]      bkey_reg, bkey_next;
    logic [ID_IW-1:0]         bid_reg, bid_next;
    logic [HC_W-1:0]          cnt_reg, cnt_next;
    logic                     up_only_reg, up_only_next;
    logic [NUM_IDS-1:0]       pvalid_reg;
    logic                     pv_set, pv_clr;
    logic [ID_IW-1:0]         pv_idx;
    logic [KEY_BITS-1:0]      root_key_reg;
    logic [ID_IW-1:0]         root_id_reg;
    logic                     out_valid_reg;
    logic [imh_pkg::STATUS_W-1:0] out_status_reg;
    logic                     out_min_valid_reg;
    logic [imh_pkg::ID_W-1:0] out_min_id_reg;
    logic [imh_pkg::KEY_W-1:0] out_min_key_reg;
    logic [imh_pkg::CNT_W-1:0] out_count_reg;
    logic                     out_load;

    logic                     heap_we;
    logic [SLOT_W-1:0]        heap_waddr, heap_raddr;
    logic [HW-1:0]            heap_wdata, heap_rdata;
    logic                     pos_we;
    logic [ID_IW-1:0]         pos_waddr, pos_raddr;
    logic [SLOT_W-1:0]        pos_wdata, pos_rdata;

    logic [KEY_BITS-1:0]      rd_key;
    logic [ID_IW-1:0]         rd_id;
    logic [XW-1:0]            l_ext, r_ext, cnt_ext;
    logic [HC_W-1:0]          last_cnt;
    logic [LW-1:0]            limit;
    logic [IDM-1:0]           root_id_wide;
    logic [KW_MAX-1:0]        root_key_wide;
    logic [CW_MAX-1:0]        cnt_wide;

    // heap slots and position table
    imh_ram #(.WIDTH(HW), .DEPTH(CAPACITY)) u_heap_ram (
        .clk   (clk),
        .we    (heap_we),
        .waddr (heap_waddr),
        .wdata (heap_wdata),
        .raddr (heap_raddr),
        .rdata (heap_rdata)
    );

    imh_ram #(.WIDTH(SLOT_W), .DEPTH(NUM_IDS)) u_pos_ram (
        .clk   (clk),
        .we    (pos_we),
        .waddr (pos_waddr),
        .wdata (pos_wdata),
        .raddr (pos_raddr),
        .rdata (pos_rdata)
    );

    // helper values
    assign rd_key   = heap_rdata[HW-1:ID_IW];
    assign rd_id    = heap_rdata[ID_IW-1:0];
    assign l_ext    = {1'b0, i_reg, 1'b0};
    assign r_ext    = {1'b0, i_reg, 1'b1};
    assign cnt_ext  = XW'(cnt_reg);
    assign last_cnt = cnt_reg - HC_W'(1);
    assign limit    = (LW'(cap_limit) < LW'(CAPACITY)) ? LW'(cap_limit) : LW'(CAPACITY);
    assign out_load = !out_valid_reg || out_ready;

    // sequencer next state and memory controls
    always_comb
    begin
        state_next   = state_reg;
        op_next      = op_reg;
        stat_next    = stat_reg;
        id_next      = id_reg;
        key_next     = key_reg;
        i_next       = i_reg;
        cur_key_next = cur_key_reg;
        cur_id_next  = cur_id_reg;
        best_next    = best_reg;
        bkey_next    = bkey_reg;
        bid_next     = bid_reg;
        cnt_next     = cnt_reg;
        up_only_next = up_only_reg;
        pv_set       = 1'b0;
        pv_clr       = 1'b0;
        pv_idx       = id_reg;
        head_pop     = 1'b0;
        heap_we      = 1'b0;
        heap_waddr   = i_reg;
        heap_wdata   = {cur_key_reg, cur_id_reg};
        heap_raddr   = i_reg;
        pos_we       = 1'b0;
        pos_waddr    = cur_id_reg;
        pos_wdata    = i_reg;
        pos_raddr    = head_id;

        unique case (state_reg)
            imh_pkg::ST_IDLE:
            begin
                if (head_ctrl.valid)
                begin
                    head_pop  = 1'b1;
                    op_next   = head_ctrl.op;
                    id_next   = head_id;
                    key_next  = head_key;
                    stat_next = imh_pkg::STAT_OK;
                    state_next = imh_pkg::ST_DONE;
                    unique case (head_ctrl.op)
                        imh_pkg::OP_QUERY:
                        begin
                            stat_next = imh_pkg::STAT_OK;
                        end
                        imh_pkg::OP_BAD_ID:
                        begin
                            stat_next = imh_pkg::STAT_ABSENT;
                        end
                        imh_pkg::OP_ADD:
                        begin
                            if (pvalid_reg[head_id])
                            begin
                                stat_next = imh_pkg::STAT_PRESENT;
                            end
                            else if (LW'(cnt_reg) >= limit)
                            begin
                                stat_next = imh_pkg::STAT_FULL;
                            end
                            else
                            begin
                                cur_key_next = head_key;
                                cur_id_next  = head_id;
                                i_next       = cnt_reg[SLOT_W-1:0];
                                cnt_next     = cnt_reg + HC_W'(1);
                                pv_set       = 1'b1;
                                pv_idx       = head_id;
                                up_only_next = 1'b1;
                                state_next   = imh_pkg::ST_UP;
                            end
                        end
                        default:
                        begin
                            if (!pvalid_reg[head_id])
                            begin
                                stat_next = imh_pkg::STAT_ABSENT;
                            end
                            else
                            begin
                                state_next = imh_pkg::ST_POS_WAIT;
                            end
                        end
                    endcase
                end
            end

            // slot of the named entry is back
            imh_pkg::ST_POS_WAIT:
            begin
                up_only_next = 1'b0;
                i_next       = pos_rdata;
                if (op_reg == imh_pkg::OP_UPDATE)
                begin
                    cur_key_next = key_reg;
                    cur_id_next  = id_reg;
                    state_next   = imh_pkg::ST_UP;
                end
                else
                begin
                    pv_clr   = 1'b1;
                    pv_idx   = id_reg;
                    cnt_next = last_cnt;
                    if (XW'(pos_rdata) == XW'(last_cnt))
                    begin
                        state_next = imh_pkg::ST_DONE;
                    end
                    else
                    begin
                        heap_raddr = last_cnt[SLOT_W-1:0];
                        state_next = imh_pkg::ST_LAST_WAIT;
                    end
                end
            end

            // last entry moves into the freed slot
            imh_pkg::ST_LAST_WAIT:
            begin
                cur_key_next = rd_key;
                cur_id_next  = rd_id;
                state_next   = imh_pkg::ST_UP;
            end

            // sift up: fetch parent
            imh_pkg::ST_UP:
            begin
                if (i_reg == '0)
                begin
                    state_next = up_only_reg ? imh_pkg::ST_WRITE : imh_pkg::ST_DOWN;
                end
                else
                begin
                    heap_raddr = i_reg >> 1;
                    state_next = imh_pkg::ST_UP_WAIT;
                end
            end

            // sift up: move a larger parent down
            imh_pkg::ST_UP_WAIT:
            begin
                if (rd_key > cur_key_reg)
                begin
                    heap_we    = 1'b1;
                    heap_wdata = heap_rdata;
                    pos_we     = 1'b1;
                    pos_waddr  = rd_id;
                    i_next     = i_reg >> 1;
                    state_next = imh_pkg::ST_UP;
                end
                else
                begin
                    state_next = up_only_reg ? imh_pkg::ST_WRITE : imh_pkg::ST_DOWN;
                end
            end

            // sift down: fetch children below the count
            imh_pkg::ST_DOWN:
            begin
                best_next = i_reg;
                bkey_next = cur_key_reg;
                bid_next  = cur_id_reg;
                if (l_ext < cnt_ext && i_reg != '0)
                begin
                    heap_raddr = l_ext[SLOT_W-1:0];
                    state_next = imh_pkg::ST_DL_WAIT;
                end
                else if (r_ext < cnt_ext)
                begin
                    heap_raddr = r_ext[SLOT_W-1:0];
                    state_next = imh_pkg::ST_DR_WAIT;
                end
                else
                begin
                    state_next = imh_pkg::ST_WRITE;
                end
            end

            imh_pkg::ST_DL_WAIT:
            begin
                if (rd_key < cur_key_reg)
                begin
                    best_next = l_ext[SLOT_W-1:0];
                    bkey_next = rd_key;
                    bid_next  = rd_id;
                end
                if (r_ext < cnt_ext)
                begin
                    heap_raddr = r_ext[SLOT_W-1:0];
                    state_next = imh_pkg::ST_DR_WAIT;
                end
                else
                begin
                    state_next = imh_pkg::ST_DECIDE;
                end
            end

            imh_pkg::ST_DR_WAIT:
            begin
                if (rd_key < bkey_reg)
                begin
                    best_next = r_ext[SLOT_W-1:0];
                    bkey_next = rd_key;
                    bid_next  = rd_id;
                end
                state_next = imh_pkg::ST_DECIDE;
            end

            // sift down: pull the smaller child up
            imh_pkg::ST_DECIDE:
            begin
                if (best_reg == i_reg)
                begin
                    state_next = imh_pkg::ST_WRITE;
                end
                else
                begin
                    heap_we    = 1'b1;
                    heap_wdata = {bkey_reg, bid_reg};
                    pos_we     = 1'b1;
                    pos_waddr  = bid_reg;
                    i_next     = best_reg;
                    state_next = imh_pkg::ST_DOWN;
                end
            end

            // place the moving entry
            imh_pkg::ST_WRITE:
            begin
                heap_we    = 1'b1;
                pos_we     = 1'b1;
                state_next = imh_pkg::ST_DONE;
            end

            imh_pkg::ST_DONE:
            begin
                if (out_load)
                begin
                    state_next = imh_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = imh_pkg::ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= imh_pkg::ST_IDLE;
            cnt_reg    <= '0;
            pvalid_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            if (pv_set)
            begin
                pvalid_reg[pv_idx] <= 1'b1;
            end
            if (pv_clr)
            begin
                pvalid_reg[pv_idx] <= 1'b0;
            end
            if (state_reg == imh_pkg::ST_DONE && out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        op_reg      <= op_next;
        stat_reg    <= stat_next;
        id_reg      <= id_next;
        key_reg     <= key_next;
        i_reg       <= i_next;
        cur_key_reg <= cur_key_next;
        cur_id_reg  <= cur_id_next;
        best_reg    <= best_next;
        bkey_reg    <= bkey_next;
        bid_reg     <= bid_next;
        up_only_reg <= up_only_next;
        if (heap_we && heap_waddr == '0)
        begin
            root_key_reg <= heap_wdata[HW-1:ID_IW];
            root_id_reg  <= heap_wdata[ID_IW-1:0];
        end
        if (state_reg == imh_pkg::ST_DONE && out_load)
        begin
            out_status_reg    <= stat_reg;
            out_min_valid_reg <= (cnt_reg != '0);
            out_min_id_reg    <= (cnt_reg != '0) ? root_id_wide[imh_pkg::ID_W-1:0] : '0;
            out_min_key_reg   <= (cnt_reg != '0) ? root_key_wide[imh_pkg::KEY_W-1:0] : '0;
            out_count_reg     <= cnt_wide[imh_pkg::CNT_W-1:0];
        end
    end

    assign root_id_wide  = IDM'(root_id_reg);
    assign root_key_wide = KW_MAX'(root_key_reg);
    assign cnt_wide      = CW_MAX'(cnt_reg);

    // result port
    assign out_valid = out_valid_reg;
    assign status    = out_status_reg;
    assign min_valid = out_min_valid_reg;
    assign min_id    = out_min_id_reg;
    assign min_key   = out_min_key_reg;
    assign count     = out_count_reg;

endmodule

FILE: rtl/imh_checker.sv
// port-level checks for the indexed min-heap, bound to the top level
`timescale 1ns / 1ps
module imh_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          out_valid,
    input logic                          out_ready,
    input logic [imh_pkg::STATUS_W-1:0]  status,
    input logic                          min_valid,
    input logic [imh_pkg::ID_W-1:0]      min_id,
    input logic [imh_pkg::KEY_W-1:0]     min_key,
    input logic [imh_pkg::CNT_W-1:0]     count,
    input logic                          pready
);

    // root flag follows the count
    a_min_valid_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (min_valid == (count != '0)))
        else $error("min_valid disagrees with count");

    // empty heap reports a zero root
    a_empty_root: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !min_valid) |-> (min_id == '0 && min_key == '0))
        else $error("empty heap shows a root");

    // a full refusal never reports a count beyond 256, the default capacity
    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status == imh_pkg::STAT_FULL) |-> (count <= 9'd256))
        else $error("count beyond capacity");

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(status) && $stable(count)))
        else $error("result changed while stalled");

    // apb never waits
    a_pready: assert property (@(posedge clk) disable iff (!rst_n) pready)
        else $error("pready low");

endmodule

bind indexed_min_heap_top imh_checker u_imh_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .min_valid (min_valid),
    .min_id    (min_id),
    .min_key   (min_key),
    .count     (count),
    .pready    (pready)
);
